[src/khbt_pkg.sv]
`default_nettype none

package khbt_pkg;

  localparam int NUM_POSITIONS = 52;

  localparam int TIME_W    = 32;
  localparam int POS_W     = 6;
  localparam int MASK_W    = 52;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] HOLD_DELAY_RST  = 16'd1009;
  localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd337;
  localparam logic [CFG_W-1:0] THROTTLE_RST    = 16'd31;

  localparam logic [TIME_W-1:0] PARK_OFFSET = 32'd2147483646;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE   = 2'd2;

endpackage

`default_nettype wire

[src/key_hold_blink_timer_unit.sv]
`default_nettype none

// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | mode, key_position, key_down, now_time
// out     | output    | out_valid/out_stall | overlay_mask
// cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Key event or tick whose throttle deadline is not due: ST_KEY or ST_THROTTLE, then ST_DONE.
// Tick that runs a sweep: ST_THROTTLE, then ST_SWEEP with one deadline read from the
// deadline RAM and one shared compare/add per cycle, then ST_DONE.
// Reset (rst, synchronous) clears flags, marks all deadlines as parked, no RAM pass.
// in_stall is high while an item is in work; a stalled result holds the block in its last step.

module key_hold_blink_timer_unit #(
  parameter int NumPositions = khbt_pkg::NUM_POSITIONS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [khbt_pkg::POS_W-1:0]     key_position,
  input  logic                           key_down,
  input  logic [khbt_pkg::TIME_W-1:0]    now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [khbt_pkg::MASK_W-1:0]    overlay_mask,
  input  logic                           cfg_write,
  input  logic [khbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khbt_pkg::CFG_W-1:0]     cfg_data
);
  import khbt_pkg::*;

  localparam int IdxW = (NumPositions > 1) ? $clog2(NumPositions) : 1;
  localparam int CntW = $clog2(NumPositions + 1);
  localparam logic [CntW-1:0]  NumPosCnt = CntW'(NumPositions);
  localparam logic [POS_W:0]   NumPosKey = (POS_W + 1)'(NumPositions);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_THROTTLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]        hold_delay;
  logic [CFG_W-1:0]        repeat_period;
  logic [CFG_W-1:0]        throttle_period;

  logic [TIME_W-1:0]       sweep_deadline;
  logic [NumPositions-1:0] flags;
  logic [NumPositions-1:0] dl_valid;

  logic                    mode_q;
  logic [POS_W-1:0]        pos_q;
  logic                    down_q;
  logic [TIME_W-1:0]       now_q;

  logic [CntW-1:0]         rd_cnt;
  logic                    ev_valid;
  logic [IdxW-1:0]         ev_idx;
  logic                    ev_known;

  logic                    in_accept;
  logic                    pos_ok;
  logic [IdxW-1:0]         key_idx;
  logic [IdxW-1:0]         rd_idx;
  logic                    issue;
  logic [TIME_W-1:0]       ram_rdata;
  logic [TIME_W-1:0]       ev_deadline;
  logic                    dl_we;
  logic [IdxW-1:0]         dl_waddr;

  logic [TIME_W-1:0]       cmp_val;
  logic [TIME_W-1:0]       add_a;
  logic [TIME_W-1:0]       add_b;
  logic                    expired;
  logic [TIME_W-1:0]       sum;

  logic [MASK_W-1:0]       mask_now;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign pos_ok  = ({1'b0, pos_q} < NumPosKey);
  assign key_idx = pos_q[IdxW-1:0];
  assign rd_idx  = rd_cnt[IdxW-1:0];
  assign issue   = (state == ST_SWEEP) && (rd_cnt < NumPosCnt);

  assign ev_deadline = ev_known ? ram_rdata : PARK_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay      <= HOLD_DELAY_RST;
      repeat_period   <= REPEAT_RST;
      throttle_period <= THROTTLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HOLD_DELAY: hold_delay      <= cfg_data;
        REG_REPEAT:     repeat_period   <= cfg_data;
        REG_THROTTLE:   throttle_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      ST_KEY: begin
        cmp_val = now_q;
        add_a   = now_q;
        add_b   = down_q ? {{(TIME_W-CFG_W){1'b0}}, hold_delay} : PARK_OFFSET;
      end
      ST_THROTTLE: begin
        cmp_val = sweep_deadline;
        add_a   = sweep_deadline;
        add_b   = {{(TIME_W-CFG_W){1'b0}}, throttle_period};
      end
      default: begin
        cmp_val = ev_deadline;
        add_a   = ev_deadline;
        add_b   = {{(TIME_W-CFG_W){1'b0}}, repeat_period};
      end
    endcase
  end

  khbt_alu u_alu (
    .now     (now_q),
    .cmp_val (cmp_val),
    .add_a   (add_a),
    .add_b   (add_b),
    .expired (expired),
    .sum     (sum)
  );

  always_comb begin
    dl_we    = ((state == ST_KEY) && pos_ok) || ((state == ST_SWEEP) && ev_valid && expired);
    dl_waddr = (state == ST_KEY) ? key_idx : ev_idx;
  end

  khbt_ram #(
    .Width (TIME_W),
    .Depth (NumPositions)
  ) u_deadlines (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (sum),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NumPositions) begin : g_on
      assign mask_now[g] = flags[g];
    end else begin : g_off
      assign mask_now[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      ev_valid       <= 1'b0;
      flags          <= '0;
      dl_valid       <= '0;
      sweep_deadline <= '0;
      rd_cnt         <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            mode_q <= mode;
            pos_q  <= key_position;
            down_q <= key_down;
            now_q  <= now_time;
            state  <= mode ? ST_THROTTLE : ST_KEY;
          end
        end
        ST_KEY: begin
          if (pos_ok) begin
            flags[key_idx]    <= down_q;
            dl_valid[key_idx] <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_THROTTLE: begin
          if (expired) begin
            sweep_deadline <= sum;
            rd_cnt         <= '0;
            ev_valid       <= 1'b0;
            state          <= ST_SWEEP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SWEEP: begin
          ev_valid <= issue;
          ev_idx   <= rd_idx;
          ev_known <= issue ? dl_valid[rd_idx] : 1'b0;
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (ev_valid && expired) begin
            flags[ev_idx]    <= ~flags[ev_idx];
            dl_valid[ev_idx] <= 1'b1;
          end
          if (!issue && !ev_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            overlay_mask <= mask_now;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ev_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == ST_SWEEP))
    else $error("eval stage active outside sweep");

  a_sweep_on_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> mode_q)
    else $error("sweep running for a key event");

  a_ev_idx_range: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> ({1'b0, ev_idx} < (IdxW + 1)'(NumPositions)))
    else $error("eval index beyond key count");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |=> (state == ST_SWEEP || state == ST_DONE))
    else $error("sweep left without result step");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside result step");

endmodule

`default_nettype wire

[src/khbt_ram.sv]
`default_nettype none

module khbt_ram #(
  parameter int Width = 32,
  parameter int Depth = 52
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                       wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                       rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/khbt_alu.sv]
`default_nettype none

module khbt_alu (
  input  logic [khbt_pkg::TIME_W-1:0] now,
  input  logic [khbt_pkg::TIME_W-1:0] cmp_val,
  input  logic [khbt_pkg::TIME_W-1:0] add_a,
  input  logic [khbt_pkg::TIME_W-1:0] add_b,
  output logic                        expired,
  output logic [khbt_pkg::TIME_W-1:0] sum
);
  import khbt_pkg::*;

  logic [TIME_W-1:0] diff;

  // wrap-around expiry: now - deadline below half range
  assign diff    = now - cmp_val;
  assign expired = ~diff[TIME_W-1];
  assign sum     = add_a + add_b;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
  import khbt_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = 1'b0;
  logic [POS_W-1:0]     key_position = '0;
  logic                 key_down = 1'b0;
  logic [TIME_W-1:0]    now_time = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MASK_W-1:0]    overlay_mask;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  always #2 clk = ~clk;

  key_hold_blink_timer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .key_position (key_position),
    .key_down     (key_down),
    .now_time     (now_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .overlay_mask (overlay_mask),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  class overlay_scoreboard;
    logic [CFG_W-1:0]         hold_delay;
    logic [CFG_W-1:0]         repeat_step;
    logic [CFG_W-1:0]         throttle_step;
    logic [NUM_POSITIONS-1:0] flags;
    logic [TIME_W-1:0]        deadline [NUM_POSITIONS];
    logic [TIME_W-1:0]        sweep_at;
    logic [MASK_W-1:0]        pending_masks [$];
    int items, results, errors, sweeps, throttled, toggles;

    function new();
      hold_delay    = HOLD_DELAY_RST;
      repeat_step   = REPEAT_RST;
      throttle_step = THROTTLE_RST;
      flags         = '0;
      foreach (deadline[i]) deadline[i] = PARK_OFFSET;
      sweep_at  = '0;
      items     = 0;
      results   = 0;
      errors    = 0;
      sweeps    = 0;
      throttled = 0;
      toggles   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_HOLD_DELAY: hold_delay = val;
        REG_REPEAT:     repeat_step = val;
        REG_THROTTLE:   throttle_step = val;
        default: ;
      endcase
    endfunction

    // wrap-around compare: due once (t - due) mod 2^32 is below 2^31
    function bit expired(logic [TIME_W-1:0] t, logic [TIME_W-1:0] due);
      logic [TIME_W-1:0] diff;
      diff = t - due;
      return ~diff[TIME_W-1];
    endfunction

    function void note_input(logic m, logic [POS_W-1:0] pos, logic down,
                             logic [TIME_W-1:0] t);
      items++;
      if (!m) begin
        if (pos < NUM_POSITIONS) begin
          flags[pos]    = down;
          deadline[pos] = t + (down ? TIME_W'(hold_delay) : PARK_OFFSET);
        end
      end else if (expired(t, sweep_at)) begin
        sweep_at = sweep_at + TIME_W'(throttle_step);
        sweeps++;
        for (int i = 0; i < NUM_POSITIONS; i++) begin
          if (expired(t, deadline[i])) begin
            deadline[i] = deadline[i] + TIME_W'(repeat_step);
            flags[i]    = ~flags[i];
            toggles++;
          end
        end
      end else begin
        throttled++;
      end
      pending_masks.push_back(MASK_W'(flags));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [MASK_W-1:0] got);
      logic [MASK_W-1:0] want;
      results++;
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("overlay_mask %h with no item pending", got));
      end else begin
        want = pending_masks.pop_front();
        if (got !== want)
          report_mismatch($sformatf("overlay_mask %h, predicted %h", got, want));
      end
    endtask
  endclass

  overlay_scoreboard sb = new();

  int               in_idle_pct = 0;
  int               out_idle_pct = 0;
  int               hold_request = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [POS_W-1:0] key_pool [8];

  task automatic send_item(logic m, logic [POS_W-1:0] pos, logic down,
                           logic [TIME_W-1:0] t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    key_position <= pos;
    key_down     <= down;
    now_time     <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(m, pos, down, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_masks.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [CFG_W-1:0] d, logic [CFG_W-1:0] r,
                             logic [CFG_W-1:0] s);
    cfg_write <= 1'b1;
    cfg_index <= REG_HOLD_DELAY;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_REPEAT;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= REG_THROTTLE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(REG_HOLD_DELAY, d);
    sb.write_reg(REG_REPEAT, r);
    sb.write_reg(REG_THROTTLE, s);
  endtask

  // mostly ticks and press/release on a small pool of keys so that deadlines
  // expire and flags blink; rare time jumps and stray key positions
  task automatic random_item(int step_max);
    logic [POS_W-1:0] pos;
    int r;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(step_max);
    if (r == 0) clock_ms = clock_ms + $urandom;
    if ($urandom_range(19) == 0) pos = POS_W'($urandom_range(63));
    else pos = key_pool[$urandom_range(7)];
    if (r < 50)
      send_item(1'b1, POS_W'($urandom_range(63)), 1'($urandom_range(1)), clock_ms);
    else
      send_item(1'b0, pos, ($urandom_range(99) < 60), clock_ms);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(overlay_mask);
      if (hold_request > 0) begin
        hold_request--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  initial begin
    #8000000;
    $display("Timeout: %0d items sent, %0d results seen", sb.items, sb.results);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int step_max;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: throttle, out-of-range keys, extremes of time, wrap-around
    send_item(1'b1, 6'd0,  1'b0, 32'd0);
    send_item(1'b1, 6'd63, 1'b1, 32'd5);
    send_item(1'b0, 6'd0,  1'b1, 32'd10);
    send_item(1'b0, 6'd51, 1'b1, 32'd12);
    send_item(1'b0, 6'd52, 1'b1, 32'd14);
    send_item(1'b0, 6'd63, 1'b0, 32'd15);
    send_item(1'b0, 6'd31, 1'b1, 32'd16);
    send_item(1'b0, 6'd32, 1'b1, 32'd17);
    send_item(1'b0, 6'd51, 1'b0, 32'd20);
    send_item(1'b1, 6'd0,  1'b0, 32'd1100);
    send_item(1'b1, 6'd0,  1'b0, 32'd1110);
    send_item(1'b0, 6'd5,  1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 6'd0,  1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 6'd0,  1'b0, 32'h7FFF_FFFF);
    send_item(1'b1, 6'd0,  1'b0, 32'h8000_0000);
    send_item(1'b1, 6'd0,  1'b0, 32'h8000_0020);
    send_item(1'b0, 6'd0,  1'b0, 32'h8000_0030);
    send_item(1'b0, 6'd7,  1'b1, 32'd2000);
    send_item(1'b1, 6'd0,  1'b0, 32'd2000);
    send_item(1'b1, 6'd0,  1'b0, 32'd3500);
    clock_ms = 32'd3500;

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      case (seg / 2)
        0: begin in_idle_pct = 23; out_idle_pct = 72; end
        1: begin in_idle_pct = 72; out_idle_pct = 23; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      case (seg)
        0: begin load_config(16'd0, 16'd1, 16'd1); step_max = 20; end
        1: begin load_config(HOLD_DELAY_RST, REPEAT_RST, THROTTLE_RST); step_max = 80; end
        2: begin load_config(16'hFFFF, 16'hFFFF, 16'hFFFF); step_max = 20000; end
        3: begin load_config(16'd0, 16'd0, 16'd0); step_max = 30; end
        4: begin
          load_config(CFG_W'($urandom_range(4000)), CFG_W'($urandom_range(1000, 1)),
                      CFG_W'($urandom_range(200, 1)));
          step_max = 300;
        end
        default: begin load_config(16'd300, 16'hFFFF, 16'd1); step_max = 100; end
      endcase
      foreach (key_pool[k]) key_pool[k] = POS_W'($urandom_range(NUM_POSITIONS - 1));
      for (int n = 0; n < 180; n++) begin
        if (seg == 1 && n == 60) hold_request = 400;
        random_item(step_max);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("%0d items over six register settings: %0d sweeps ran, %0d ticks throttled,",
             sb.items, sb.sweeps, sb.throttled);
    $display("%0d flag toggles predicted, %0d masks checked, %0d mismatches",
             sb.toggles, sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
